// ----- hdl/v6lpm_pkg.sv -----
`default_nettype none

package v6lpm_pkg;

    localparam int unsigned TABLE_DEPTH_DEF = 64;

    localparam int unsigned ADDR_W   = 64;
    localparam int unsigned LEN_W    = 8;
    localparam int unsigned SLOT_W   = 6;
    localparam int unsigned PLANE_W  = 8;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned EIU_W    = 7;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [LEN_W-1:0] FULL_LEN = 8'd128;

    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_PLANE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_IN_USE = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_WRITTEN = 3'd0,
        ST_ERROR   = 3'd1,
        ST_ALL     = 3'd2,
        ST_ONE     = 3'd3,
        ST_NONE    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        K_WRITTEN = 2'd0,
        K_ERROR   = 2'd1,
        K_ALL     = 2'd2,
        K_SCAN    = 2'd3
    } t_kind;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr_high;
        logic [ADDR_W-1:0]  addr_low;
        logic [LEN_W-1:0]   length;
        logic [PLANE_W-1:0] assignee;
    } t_entry;

    typedef struct packed {
        logic  load;
        logic  mem_write;
        logic  scan_clear;
        logic  scan_step;
        logic  emit;
        t_kind kind;
    } t_cmd;

    typedef struct packed {
        logic is_write;
        logic no_planes;
        logic zero_addr;
        logic len_zero;
        logic len_full;
        logic count_zero;
        logic scan_last;
    } t_stat;

endpackage

`default_nettype wire

// ----- hdl/v6lpm_ctrl.sv -----
`default_nettype none

module v6lpm_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire v6lpm_pkg::t_stat i_stat,
    output v6lpm_pkg::t_cmd       o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_CHECK  = 5'b00010,
        S_SCAN   = 5'b00100,
        S_DRAIN  = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.kind = v6lpm_pkg::K_SCAN;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.is_write) begin
                    o_cmd.mem_write = 1'b1;
                    o_cmd.emit      = 1'b1;
                    o_cmd.kind      = v6lpm_pkg::K_WRITTEN;
                    n_state         = S_IDLE;
                end else if (i_stat.no_planes ||
                             (i_stat.zero_addr && i_stat.len_full)) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = v6lpm_pkg::K_ERROR;
                    n_state    = S_IDLE;
                end else if (i_stat.zero_addr && i_stat.len_zero) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = v6lpm_pkg::K_ALL;
                    n_state    = S_IDLE;
                end else begin
                    o_cmd.scan_clear = 1'b1;
                    n_state = i_stat.count_zero ? S_FINISH : S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                o_cmd.emit = 1'b1;
                o_cmd.kind = v6lpm_pkg::K_SCAN;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

// ----- hdl/v6lpm_dp.sv -----
`default_nettype none

module v6lpm_dp #(
    parameter int unsigned TABLE_DEPTH = v6lpm_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [v6lpm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [v6lpm_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  wire logic                                i_op,
    input  wire logic [v6lpm_pkg::ADDR_W-1:0]        i_addr_high,
    input  wire logic [v6lpm_pkg::ADDR_W-1:0]        i_addr_low,
    input  wire logic [v6lpm_pkg::LEN_W-1:0]         i_prefix_len,
    input  wire logic                                i_exact_mode,
    input  wire logic [v6lpm_pkg::SLOT_W-1:0]        i_slot,
    input  wire logic [v6lpm_pkg::PLANE_W-1:0]       i_assignee,
    input  wire v6lpm_pkg::t_cmd                     i_cmd,
    output v6lpm_pkg::t_stat                         o_stat,
    output logic                                     o_valid,
    output logic [v6lpm_pkg::STATUS_W-1:0]           o_status,
    output logic [v6lpm_pkg::PLANE_W-1:0]            o_plane_index
);

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned XW = (CW > v6lpm_pkg::EIU_W) ? CW : v6lpm_pkg::EIU_W;
    localparam int unsigned SW = (CW > v6lpm_pkg::SLOT_W) ? CW : v6lpm_pkg::SLOT_W;
    localparam int unsigned QW = 2 * v6lpm_pkg::ADDR_W;

    logic [v6lpm_pkg::PLANE_W-1:0] r_plane_count;
    logic [v6lpm_pkg::PLANE_W-1:0] r_default_plane;
    logic [v6lpm_pkg::EIU_W-1:0]   r_eiu;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane_count   <= '0;
            r_default_plane <= '0;
            r_eiu           <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                v6lpm_pkg::CFG_PLANE_COUNT:    r_plane_count   <= i_cfg_wdata;
                v6lpm_pkg::CFG_DEFAULT_PLANE:  r_default_plane <= i_cfg_wdata;
                v6lpm_pkg::CFG_ENTRIES_IN_USE: r_eiu <= i_cfg_wdata[v6lpm_pkg::EIU_W-1:0];
                default: begin
                end
            endcase
        end
    end

    logic                          r_op;
    logic [v6lpm_pkg::ADDR_W-1:0]  r_ah;
    logic [v6lpm_pkg::ADDR_W-1:0]  r_al;
    logic [v6lpm_pkg::LEN_W-1:0]   r_qlen;
    logic                          r_exact;
    logic [v6lpm_pkg::SLOT_W-1:0]  r_slot;
    logic [v6lpm_pkg::PLANE_W-1:0] r_who;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_ah    <= i_addr_high;
            r_al    <= i_addr_low;
            r_qlen  <= i_prefix_len;
            r_exact <= i_exact_mode;
            r_slot  <= i_slot;
            r_who   <= i_assignee;
        end
    end

    logic [XW-1:0] eiu_x;
    logic [XW-1:0] depth_x;
    logic [CW-1:0] count;
    logic [SW-1:0] slot_x;
    logic          slot_ok;

    assign eiu_x   = XW'(r_eiu);
    assign depth_x = XW'(TABLE_DEPTH);
    assign count   = (eiu_x > depth_x) ? depth_x[CW-1:0] : eiu_x[CW-1:0];
    assign slot_x  = SW'(r_slot);
    assign slot_ok = (slot_x < SW'(TABLE_DEPTH));

    v6lpm_pkg::t_entry r_mem [TABLE_DEPTH];
    v6lpm_pkg::t_entry r_rd;
    logic              r_rd_vld;
    logic [CW-1:0]     r_idx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_write && slot_ok) begin
            r_mem[slot_x[AW-1:0]] <= '{addr_high: r_ah, addr_low: r_al,
                                       length: r_qlen, assignee: r_who};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step) begin
            r_rd <= r_mem[r_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_rd_vld <= i_cmd.scan_step;
            if (i_cmd.scan_clear) begin
                r_idx <= '0;
            end else if (i_cmd.scan_step) begin
                r_idx <= r_idx + CW'(1);
            end
        end
    end

    logic [v6lpm_pkg::LEN_W-1:0] eff_q;
    logic [QW-1:0]               mask;
    logic [QW-1:0]               diff;
    logic                        hit;

    assign eff_q = (r_qlen > v6lpm_pkg::FULL_LEN) ? v6lpm_pkg::FULL_LEN : r_qlen;
    assign mask  = ~({QW{1'b1}} >> r_rd.length);
    assign diff  = {r_ah, r_al} ^ {r_rd.addr_high, r_rd.addr_low};
    assign hit   = (r_rd.length <= v6lpm_pkg::FULL_LEN)
                && (!r_exact || (r_rd.length == r_qlen))
                && (r_rd.length <= eff_q)
                && ((diff & mask) == '0);

    logic                          r_found;
    logic [v6lpm_pkg::LEN_W-1:0]   r_best_len;
    logic [v6lpm_pkg::PLANE_W-1:0] r_best_who;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_cmd.scan_clear) begin
            r_found <= 1'b0;
        end else if (r_rd_vld && hit && (!r_found || (r_rd.length >= r_best_len))) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_vld && hit && (!r_found || (r_rd.length >= r_best_len))) begin
            r_best_len <= r_rd.length;
            r_best_who <= r_rd.assignee;
        end
    end

    logic                          r_valid;
    v6lpm_pkg::t_status            r_status;
    logic [v6lpm_pkg::PLANE_W-1:0] r_plane;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            case (i_cmd.kind)
                v6lpm_pkg::K_WRITTEN: begin
                    r_status <= v6lpm_pkg::ST_WRITTEN;
                    r_plane  <= '0;
                end
                v6lpm_pkg::K_ERROR: begin
                    r_status <= v6lpm_pkg::ST_ERROR;
                    r_plane  <= '0;
                end
                v6lpm_pkg::K_ALL: begin
                    r_status <= v6lpm_pkg::ST_ALL;
                    r_plane  <= '0;
                end
                v6lpm_pkg::K_SCAN: begin
                    r_status <= r_found ? v6lpm_pkg::ST_ONE : v6lpm_pkg::ST_NONE;
                    r_plane  <= r_found ? r_best_who : r_default_plane;
                end
                default: begin
                    r_status <= v6lpm_pkg::ST_ERROR;
                    r_plane  <= '0;
                end
            endcase
        end
    end

    assign o_stat.is_write   = !r_op;
    assign o_stat.no_planes  = (r_plane_count == '0);
    assign o_stat.zero_addr  = ((r_ah | r_al) == '0);
    assign o_stat.len_zero   = (r_qlen == '0);
    assign o_stat.len_full   = (r_qlen == v6lpm_pkg::FULL_LEN);
    assign o_stat.count_zero = (count == '0);
    assign o_stat.scan_last  = ((r_idx + CW'(1)) == count);

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_plane_index = r_plane;

endmodule

`default_nettype wire

// ----- hdl/ipv6_prefix_longest_match_core.sv -----
// Channel  Handshake            Payload
// -------  -------------------  ---------------------------------------------
// input    start, busy          i_op, i_addr_high, i_addr_low, i_prefix_len,
//                               i_exact_mode, i_slot, i_assignee
// result   o_valid              o_status, o_plane_index
// config   i_cfg_we             i_cfg_idx, i_cfg_wdata
//
// A write beat shows its result after the check state. A scanning lookup beat
// passes through the check, scan, drain and finish states, skipping scan and
// drain when N is zero, where N is the number of entries scanned; the table
// memory delivers one entry per cycle and the drain state lets the last entry be compared.
// A new beat may be accepted in the cycle the previous result is shown.
// Reset is synchronous and active low; the table holds no reset state.
// The result strobe lasts one cycle and cannot be stalled.
`default_nettype none

module ipv6_prefix_longest_match_core #(
    parameter int unsigned TABLE_DEPTH = v6lpm_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic                                i_op,
    input  wire logic [v6lpm_pkg::ADDR_W-1:0]        i_addr_high,
    input  wire logic [v6lpm_pkg::ADDR_W-1:0]        i_addr_low,
    input  wire logic [v6lpm_pkg::LEN_W-1:0]         i_prefix_len,
    input  wire logic                                i_exact_mode,
    input  wire logic [v6lpm_pkg::SLOT_W-1:0]        i_slot,
    input  wire logic [v6lpm_pkg::PLANE_W-1:0]       i_assignee,
    input  wire logic                                i_cfg_we,
    input  wire logic [v6lpm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [v6lpm_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    output logic                                     o_valid,
    output logic [v6lpm_pkg::STATUS_W-1:0]           o_status,
    output logic [v6lpm_pkg::PLANE_W-1:0]            o_plane_index
);

    v6lpm_pkg::t_cmd  cmd;
    v6lpm_pkg::t_stat stat;

    v6lpm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    v6lpm_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_op          (i_op),
        .i_addr_high   (i_addr_high),
        .i_addr_low    (i_addr_low),
        .i_prefix_len  (i_prefix_len),
        .i_exact_mode  (i_exact_mode),
        .i_slot        (i_slot),
        .i_assignee    (i_assignee),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_plane_index (o_plane_index)
    );

endmodule

`default_nettype wire

// ----- hdl/v6lpm_chk.sv -----
`default_nettype none

module v6lpm_chk (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                start,
    input wire logic                                busy,
    input wire logic                                i_op,
    input wire logic                                o_valid,
    input wire logic [v6lpm_pkg::STATUS_W-1:0]      o_status,
    input wire logic [v6lpm_pkg::PLANE_W-1:0]       o_plane_index
);

    logic accept;
    assign accept = start && !busy;

    a_accept_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("block not busy after an accepted beat");

    a_write_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_op) |=> ##1 (o_valid && (o_status == v6lpm_pkg::ST_WRITTEN)))
        else $error("write beat did not report written two cycles later");

    a_strobe_single : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe lasted more than one cycle");

    a_status_legal : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status <= v6lpm_pkg::ST_NONE))
        else $error("illegal result status");

    a_plane_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && ((o_status == v6lpm_pkg::ST_WRITTEN) ||
                     (o_status == v6lpm_pkg::ST_ERROR) ||
                     (o_status == v6lpm_pkg::ST_ALL))) |-> (o_plane_index == '0))
        else $error("plane index not zero for a status without a plane");

endmodule

bind ipv6_prefix_longest_match_core v6lpm_chk u_v6lpm_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_op          (i_op),
    .o_valid       (o_valid),
    .o_status      (o_status),
    .o_plane_index (o_plane_index)
);

`default_nettype wire
